FILE: rtl/ivab_pkg.sv
// Shared constants, types and helpers for the interrupt vector allocator and binder.
// Used by ivab_pin_table, ivab_vec_store and irq_vector_allocator_binder.
package ivab_pkg;

  // Managed vectors run from VecBase up to VectorEnd-1.
  localparam int VectorEnd  = 232;
  localparam int MaxPins    = 256;
  localparam int HandleBits = 16;

  localparam logic [7:0] VecBase     = 8'h20;
  localparam logic [7:0] VecSeed     = 8'h34;
  localparam logic [7:0] PinReserved = 8'hff;

  localparam int NumVec   = VectorEnd - 32;
  localparam int VecIdxW  = (NumVec > 1) ? $clog2(NumVec) : 1;
  localparam int PinAddrW = (MaxPins > 1) ? $clog2(MaxPins) : 1;

  localparam logic [7:0] VecEnd8  = 8'(VectorEnd);
  localparam logic [8:0] MaxPins9 = 9'(MaxPins);

  // Handles keep only HandleBits low bits.
  localparam logic [15:0] HandleMask = 16'((65'd1 << HandleBits) - 65'd1);

  // Operation codes.
  localparam logic [2:0] OpBind    = 3'd0;
  localparam logic [2:0] OpUnbind  = 3'd1;
  localparam logic [2:0] OpReserve = 3'd2;
  localparam logic [2:0] OpLookup  = 3'd3;
  localparam logic [2:0] OpAddFree = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIN,
    ST_HND,
    ST_WALK,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic                we;
    logic [PinAddrW-1:0] waddr;
    logic [7:0]          wdata;
    logic [PinAddrW-1:0] raddr;
  } pt_req_t;

  typedef struct packed {
    logic               nf_we;
    logic [VecIdxW-1:0] nf_waddr;
    logic [7:0]         nf_wdata;
    logic [VecIdxW-1:0] nf_raddr;
    logic               hd_we;
    logic [VecIdxW-1:0] hd_waddr;
    logic [15:0]        hd_wdata;
    logic [VecIdxW-1:0] hd_raddr;
  } vs_req_t;

  function automatic logic managed(input logic [7:0] v);
    return (v >= VecBase) && (v < VecEnd8);
  endfunction

  function automatic logic [VecIdxW-1:0] vec_idx(input logic [7:0] v);
    logic [7:0] d;
    d = v - VecBase;
    return d[VecIdxW-1:0];
  endfunction

endpackage

FILE: rtl/ivab_pin_table.sv
// Per-pin vector table: one write port, one registered read port.
// Entries read as zero until written; valid bits are cleared by reset.
// Depends on ivab_pkg.
module ivab_pin_table (
  input  logic              clk,
  input  logic              rst,
  input  ivab_pkg::pt_req_t req,
  output logic [7:0]        rdata
);

  logic [7:0]                  mem [ivab_pkg::MaxPins];
  logic [ivab_pkg::MaxPins-1:0] vld;
  logic [7:0]                  rd_mem;
  logic                        rd_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (req.we) begin
      vld[req.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_mem <= mem[req.raddr];
    rd_vld <= vld[req.raddr];
  end

  // unwritten entries read as unbound
  assign rdata = rd_vld ? rd_mem : 8'h00;

endmodule

FILE: rtl/ivab_vec_store.sv
// Per-vector stores: free-list links and bound handles.
// Each has one write and one registered read port. Depends on ivab_pkg.
module ivab_vec_store (
  input  logic              clk,
  input  ivab_pkg::vs_req_t req,
  output logic [7:0]        nf_rdata,
  output logic [15:0]       hd_rdata
);

  logic [7:0]  next_free     [ivab_pkg::NumVec];
  logic [15:0] vector_handle [ivab_pkg::NumVec];

  always_ff @(posedge clk) begin
    if (req.nf_we) begin
      next_free[req.nf_waddr] <= req.nf_wdata;
    end
    nf_rdata <= next_free[req.nf_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.hd_we) begin
      vector_handle[req.hd_waddr] <= req.hd_wdata;
    end
    hd_rdata <= vector_handle[req.hd_raddr];
  end

endmodule

FILE: rtl/irq_vector_allocator_binder.sv
// Top level of the interrupt vector allocator and pin binder: sequencer,
// free-list walker and result register. Depends on ivab_pkg, ivab_pin_table, ivab_vec_store.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------------
//  in       | in_valid / in_ready  | opcode, pin, vector_number, range_end, irq_handle
//  out      | out_valid / out_ready| success, vector_out, handle_out, pool_empty
//  cfg      | cfg_wr_en (no wait)  | cfg_wr_data (pin_count)
//
// Sequence: bind, reserve and unknown opcodes go from accept through ST_PIN to ST_RESP;
// unbind and lookup add ST_HND (pin table read, then handle read). Add-free with a good
// range goes through ST_WALK, where the walker links one vector per cycle through the
// single next_free write port; a rejected range goes straight to ST_RESP.
// A pin_count write to an empty pool seeds it with vectors 0x34 to VectorEnd-1 by the
// same walk, with in_ready low throughout.
// Reset clears the pin table valid bits at once; no clearing pass is needed.
// in_ready drops while a transaction is in flight and during a cfg write; a
// stalled result holds in the output register until out_ready.
module irq_vector_allocator_binder (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [7:0]  pin,
  input  logic [7:0]  vector_number,
  input  logic [7:0]  range_end,
  input  logic [15:0] irq_handle,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        success,
  output logic [7:0]  vector_out,
  output logic [15:0] handle_out,
  output logic        pool_empty,

  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data
);

  ivab_pkg::state_t  state, state_next;
  ivab_pkg::pt_req_t pt_req;
  ivab_pkg::vs_req_t vs_req;

  logic [7:0]  pt_rdata;
  logic [7:0]  nf_rdata;
  logic [15:0] hd_rdata;

  // Captured transaction
  logic [2:0]  op;
  logic [7:0]  pin_q;
  logic [7:0]  vec_q;
  logic [7:0]  rend_q;
  logic [15:0] hnd_q;
  logic [7:0]  pin_vec, pin_vec_next;

  // Configuration and list head
  logic [8:0]  pin_count;
  logic [7:0]  free_head, free_head_next;

  // Walker
  logic [7:0]  cur, cur_next;
  logic [7:0]  walk_end, walk_end_next;
  logic [7:0]  walk_start, walk_start_next;
  logic [7:0]  walk_tail, walk_tail_next;
  logic        walk_cfg, walk_cfg_next;
  logic [7:0]  cur_inc;
  logic        walk_last;

  // Pending result
  logic        res_ok, res_ok_next;
  logic [7:0]  res_vec, res_vec_next;
  logic [15:0] res_hnd, res_hnd_next;

  logic        accept;
  logic        cfg_seed;
  logic        pin_ok;
  logic [8:0]  pins_eff;
  logic        bind_ok;
  logic        addfree_ok;
  logic        out_load;

  ivab_pin_table u_pin_table (
    .clk   (clk),
    .rst   (rst),
    .req   (pt_req),
    .rdata (pt_rdata)
  );

  ivab_vec_store u_vec_store (
    .clk      (clk),
    .req      (vs_req),
    .nf_rdata (nf_rdata),
    .hd_rdata (hd_rdata)
  );

  assign in_ready = (state == ivab_pkg::ST_IDLE) && !cfg_wr_en;
  assign accept   = in_valid && in_ready;

  // Seed the pool on a pin_count write while idle and the list is empty.
  assign cfg_seed = cfg_wr_en && (state == ivab_pkg::ST_IDLE) && (free_head == 8'h00) &&
                    (ivab_pkg::VecEnd8 > ivab_pkg::VecSeed);

  assign pins_eff = (pin_count > ivab_pkg::MaxPins9) ? ivab_pkg::MaxPins9 : pin_count;
  assign pin_ok   = {1'b0, pin_q} < pins_eff;

  assign bind_ok = pin_ok && (vec_q < ivab_pkg::VecEnd8) &&
                   ((vec_q == 8'h00) || (vec_q >= ivab_pkg::VecBase)) && (pt_rdata == 8'h00);
  assign addfree_ok = (vec_q >= ivab_pkg::VecBase) && (vec_q < rend_q) &&
                      (rend_q <= ivab_pkg::VecEnd8);

  // Shared walker increment and end compare
  assign cur_inc   = cur + 8'd1;
  assign walk_last = (cur_inc == walk_end);

  assign out_load = (state == ivab_pkg::ST_RESP) && (!out_valid || out_ready);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ivab_pkg::ST_IDLE: begin
        if (cfg_seed) begin
          state_next = ivab_pkg::ST_WALK;
        end else if (accept) begin
          state_next = ivab_pkg::ST_PIN;
        end
      end
      ivab_pkg::ST_PIN: begin
        case (op)
          ivab_pkg::OpUnbind, ivab_pkg::OpLookup: state_next = ivab_pkg::ST_HND;
          ivab_pkg::OpAddFree: begin
            state_next = addfree_ok ? ivab_pkg::ST_WALK : ivab_pkg::ST_RESP;
          end
          default: state_next = ivab_pkg::ST_RESP;
        endcase
      end
      ivab_pkg::ST_HND: state_next = ivab_pkg::ST_RESP;
      ivab_pkg::ST_WALK: begin
        if (walk_last) begin
          state_next = walk_cfg ? ivab_pkg::ST_IDLE : ivab_pkg::ST_RESP;
        end
      end
      ivab_pkg::ST_RESP: begin
        if (out_load) begin
          state_next = ivab_pkg::ST_IDLE;
        end
      end
      default: state_next = ivab_pkg::ST_IDLE;
    endcase
  end

  // Memory requests and datapath next values
  always_comb begin
    logic [7:0] v;
    v = vec_q;

    pt_req       = '0;
    pt_req.raddr = pin[ivab_pkg::PinAddrW-1:0];
    pt_req.waddr = pin_q[ivab_pkg::PinAddrW-1:0];

    vs_req          = '0;
    vs_req.nf_raddr = ivab_pkg::vec_idx(free_head);
    vs_req.hd_raddr = ivab_pkg::vec_idx(pt_rdata);

    free_head_next  = free_head;
    pin_vec_next    = pin_vec;
    cur_next        = cur;
    walk_end_next   = walk_end;
    walk_start_next = walk_start;
    walk_tail_next  = walk_tail;
    walk_cfg_next   = walk_cfg;
    res_ok_next     = res_ok;
    res_vec_next    = res_vec;
    res_hnd_next    = res_hnd;

    case (state)
      ivab_pkg::ST_IDLE: begin
        if (cfg_seed) begin
          cur_next        = ivab_pkg::VecSeed;
          walk_start_next = ivab_pkg::VecSeed;
          walk_end_next   = ivab_pkg::VecEnd8;
          walk_tail_next  = free_head;
          walk_cfg_next   = 1'b1;
        end
      end

      ivab_pkg::ST_PIN: begin
        res_ok_next  = 1'b0;
        res_vec_next = 8'h00;
        res_hnd_next = 16'h0000;
        pin_vec_next = pt_rdata;
        case (op)
          ivab_pkg::OpBind: begin
            if (bind_ok) begin
              // dynamic request: pop the head of the free list
              if (vec_q == 8'h00 && free_head != 8'h00) begin
                v = free_head;
                free_head_next = ivab_pkg::managed(free_head) ? nf_rdata : 8'h00;
              end
              if (ivab_pkg::managed(v)) begin
                pt_req.we       = 1'b1;
                pt_req.wdata    = v;
                vs_req.hd_we    = 1'b1;
                vs_req.hd_waddr = ivab_pkg::vec_idx(v);
                vs_req.hd_wdata = hnd_q;
                res_ok_next     = 1'b1;
                res_vec_next    = v;
              end
            end
          end
          ivab_pkg::OpReserve: begin
            if (pin_ok && pt_rdata == 8'h00) begin
              pt_req.we    = 1'b1;
              pt_req.wdata = ivab_pkg::PinReserved;
              res_ok_next  = 1'b1;
              res_vec_next = ivab_pkg::PinReserved;
            end
          end
          ivab_pkg::OpAddFree: begin
            if (addfree_ok) begin
              cur_next        = vec_q;
              walk_start_next = vec_q;
              walk_end_next   = rend_q;
              walk_tail_next  = free_head;
              walk_cfg_next   = 1'b0;
              res_ok_next     = 1'b1;
              res_vec_next    = vec_q;
            end
          end
          default: begin
          end
        endcase
      end

      ivab_pkg::ST_HND: begin
        if (pin_ok && ivab_pkg::managed(pin_vec)) begin
          if (op == ivab_pkg::OpUnbind) begin
            if (hd_rdata == hnd_q) begin
              // free the vector: clear binding, push it on the list
              vs_req.hd_we    = 1'b1;
              vs_req.hd_waddr = ivab_pkg::vec_idx(pin_vec);
              vs_req.hd_wdata = 16'h0000;
              vs_req.nf_we    = 1'b1;
              vs_req.nf_waddr = ivab_pkg::vec_idx(pin_vec);
              vs_req.nf_wdata = free_head;
              pt_req.we       = 1'b1;
              pt_req.wdata    = 8'h00;
              free_head_next  = pin_vec;
              res_ok_next     = 1'b1;
              res_vec_next    = pin_vec;
            end
          end else begin
            res_ok_next  = 1'b1;
            res_vec_next = pin_vec;
            res_hnd_next = hd_rdata;
          end
        end
      end

      ivab_pkg::ST_WALK: begin
        // link one vector per cycle; the last one points at the old head
        vs_req.nf_we    = 1'b1;
        vs_req.nf_waddr = ivab_pkg::vec_idx(cur);
        vs_req.nf_wdata = walk_last ? walk_tail : cur_inc;
        cur_next        = cur_inc;
        if (walk_last) begin
          free_head_next = walk_start;
        end
      end

      ivab_pkg::ST_RESP: begin
      end

      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ivab_pkg::ST_IDLE;
      free_head <= 8'h00;
      pin_count <= 9'd0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      if (cfg_wr_en) begin
        pin_count <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= opcode;
      pin_q  <= pin;
      vec_q  <= vector_number;
      rend_q <= range_end;
      hnd_q  <= irq_handle & ivab_pkg::HandleMask;
    end
    pin_vec    <= pin_vec_next;
    cur        <= cur_next;
    walk_end   <= walk_end_next;
    walk_start <= walk_start_next;
    walk_tail  <= walk_tail_next;
    walk_cfg   <= walk_cfg_next;
    res_ok     <= res_ok_next;
    res_vec    <= res_vec_next;
    res_hnd    <= res_hnd_next;
    if (out_load) begin
      success    <= res_ok;
      vector_out <= res_vec;
      handle_out <= res_hnd;
      pool_empty <= (free_head == 8'h00);
    end
  end

endmodule

FILE: tb/ivab_reply_checker.sv
// Reply checker for irq_vector_allocator_binder: shadows the free list, pin table
// and handle table, predicts the reply to each accepted transaction and compares it.
// Depends on ivab_pkg for widths, operation codes and the managed vector range.
module ivab_reply_checker
  import ivab_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [7:0]  pin,
  input  logic [7:0]  vector_number,
  input  logic [7:0]  range_end,
  input  logic [15:0] irq_handle,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        success,
  input  logic [7:0]  vector_out,
  input  logic [15:0] handle_out,
  input  logic        pool_empty,
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic        ok;
    logic [7:0]  vec;
    logic [15:0] hnd;
    logic        empty;
  } reply_t;

  logic [8:0]  pin_limit;
  logic [7:0]  head;
  logic [7:0]  link_of    [NumVec];
  logic [7:0]  vec_of_pin [MaxPins];
  logic [15:0] hnd_of_vec [NumVec];
  reply_t      awaited    [$];

  function automatic bit in_pool(input int v);
    return v >= VecBase && v < VectorEnd;
  endfunction

  // Link first .. stop-1 in ascending order and push the run onto the list head.
  function automatic void chain_range(input int first, input int stop);
    for (int v = first; v + 1 < stop; v++)
      link_of[v - VecBase] = 8'(v + 1);
    link_of[stop - 1 - VecBase] = head;
    head = 8'(first);
  endfunction

  function automatic reply_t predict_reply(input logic [2:0] op, input logic [7:0] p,
                                           input logic [7:0] v_req, input logic [7:0] v_stop,
                                           input logic [15:0] h);
    reply_t r;
    int     eff;
    int     v;
    bit     pin_ok;
    r      = '0;
    eff    = (int'(pin_limit) < MaxPins) ? int'(pin_limit) : MaxPins;
    pin_ok = int'(p) < eff;
    h      = h & HandleMask;
    case (op)
      OpBind: begin
        if (pin_ok && v_req < VectorEnd && (v_req == 0 || v_req >= VecBase) &&
            vec_of_pin[p] == 0) begin
          v = v_req;
          if (v == 0 && head != 0) begin
            v    = head;
            head = in_pool(v) ? link_of[v - VecBase] : 8'd0;
          end
          if (in_pool(v)) begin
            vec_of_pin[p]         = 8'(v);
            hnd_of_vec[v - VecBase] = h;
            r.ok  = 1'b1;
            r.vec = 8'(v);
          end
        end
      end
      OpUnbind: begin
        v = vec_of_pin[p];
        if (pin_ok && in_pool(v) && hnd_of_vec[v - VecBase] == h) begin
          hnd_of_vec[v - VecBase] = '0;
          vec_of_pin[p]           = '0;
          link_of[v - VecBase]    = head;
          head  = 8'(v);
          r.ok  = 1'b1;
          r.vec = 8'(v);
        end
      end
      OpReserve: begin
        if (pin_ok && vec_of_pin[p] == 0) begin
          vec_of_pin[p] = PinReserved;
          r.ok  = 1'b1;
          r.vec = PinReserved;
        end
      end
      OpLookup: begin
        v = vec_of_pin[p];
        if (pin_ok && in_pool(v)) begin
          r.ok  = 1'b1;
          r.vec = 8'(v);
          r.hnd = hnd_of_vec[v - VecBase];
        end
      end
      OpAddFree: begin
        if (v_req >= VecBase && v_req < v_stop && v_stop <= VectorEnd) begin
          chain_range(v_req, v_stop);
          r.ok  = 1'b1;
          r.vec = v_req;
        end
      end
      default: ;
    endcase
    r.empty = (head == 0);
    return r;
  endfunction

  task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      pin_limit = '0;
      head      = '0;
      foreach (vec_of_pin[i]) vec_of_pin[i] = '0;
      foreach (link_of[i]) begin
        link_of[i]    = '0;
        hnd_of_vec[i] = '0;
      end
      awaited.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          mismatches++;
          $display("%0t: reply with none expected, expected none actual %0b/%0h/%0h/%0b",
                   $time, success, vector_out, handle_out, pool_empty);
        end else begin
          want = awaited.pop_front();
          check_field("success", want.ok, success);
          check_field("vector_out", want.vec, vector_out);
          check_field("handle_out", want.hnd, handle_out);
          check_field("pool_empty", want.empty, pool_empty);
        end
      end
      // Bringing the controller up seeds an empty pool.
      if (cfg_wr_en) begin
        pin_limit = cfg_wr_data;
        if (head == 0 && VectorEnd > VecSeed)
          chain_range(VecSeed, VectorEnd);
      end
      if (in_valid && in_ready)
        awaited.push_back(predict_reply(opcode, pin, vector_number, range_end, irq_handle));
    end
    outstanding = awaited.size();
  end

endmodule

FILE: tb/tb_irq_vector_allocator_binder.sv
// Testbench top for irq_vector_allocator_binder: clock, reset, directed and random
// transactions, receiver back-pressure and the verdict. Depends on ivab_pkg and
// ivab_reply_checker, which does all prediction and comparison.
module tb_irq_vector_allocator_binder;
  import ivab_pkg::*;

  localparam int HoldCycles   = 300;  // long receiver hold-off to fill the block
  localparam int SettleCycles = 250;  // covers a full-range add-free or a seed walk
  localparam int PhaseCount   = 6;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        in_valid      = 1'b0;
  logic [2:0]  opcode        = '0;
  logic [7:0]  pin           = '0;
  logic [7:0]  vector_number = '0;
  logic [7:0]  range_end     = '0;
  logic [15:0] irq_handle    = '0;
  logic        out_ready     = 1'b0;
  logic        cfg_wr_en     = 1'b0;
  logic [8:0]  cfg_wr_data   = '0;

  logic        in_ready;
  logic        out_valid;
  logic        success;
  logic [7:0]  vector_out;
  logic [15:0] handle_out;
  logic        pool_empty;

  int          mismatches;
  int          outstanding;

  // Idle percentages per side, changed between phases.
  int          send_idle_pct = 13;
  int          recv_idle_pct = 70;
  // Effective pin count as last written, used to steer pin selection.
  int          pins_live     = 0;
  // Bumped by the stimulus to ask the receiver for one long hold-off.
  int          hold_stamp    = 0;
  // Per-pin handle, so that most unbinds present the handle the pin was bound with.
  logic [15:0] pin_handle [MaxPins];

  always #5 clk = ~clk;

  irq_vector_allocator_binder DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .pin           (pin),
    .vector_number (vector_number),
    .range_end     (range_end),
    .irq_handle    (irq_handle),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .success       (success),
    .vector_out    (vector_out),
    .handle_out    (handle_out),
    .pool_empty    (pool_empty),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  ivab_reply_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .pin           (pin),
    .vector_number (vector_number),
    .range_end     (range_end),
    .irq_handle    (irq_handle),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .success       (success),
    .vector_out    (vector_out),
    .handle_out    (handle_out),
    .pool_empty    (pool_empty),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  // Receiver: drop ready at random, or hold it low for a long, self-counted
  // stretch whenever the stimulus asks, while the sender keeps offering.
  initial begin : reply_sink
    int hold_served;
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (hold_stamp != hold_served) begin
        hold_served = hold_stamp;
        out_ready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one transaction and return at the edge that accepts it. Valid is left
  // high; the next call either drops it for a gap or presents the next payload.
  task automatic offer_txn(input logic [2:0] op, input logic [7:0] p, input logic [7:0] v,
                           input logic [7:0] e, input logic [15:0] h);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    opcode        <= op;
    pin           <= p;
    vector_number <= v;
    range_end     <= e;
    irq_handle    <= h;
    do begin
      @(posedge clk);
    end while (!in_ready);
  endtask

  // Write pin_count only once the block is idle: every reply in, then a settle
  // pause long enough for any walk still running.
  task automatic write_pin_count(input logic [8:0] value);
    in_valid <= 1'b0;
    // one edge first, so the checker has booked the last accepted transaction
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pins_live = (value < MaxPins) ? int'(value) : MaxPins;
  endtask

  // One random transaction. Mostly well-formed: pins crowd into the low end so
  // that binds, lookups and unbinds meet each other, and unbinds usually carry
  // the right handle. The rest is noise over the full field ranges.
  task automatic random_txn();
    int          roll;
    int          crowd;
    int          first;
    int          stop;
    logic [2:0]  op;
    logic [7:0]  p;
    logic [7:0]  v;
    logic [7:0]  e;
    logic [15:0] h;
    crowd = (pins_live < 48) ? pins_live : 48;
    roll  = $urandom_range(99);
    if (pins_live > 0 && roll < 70) p = 8'($urandom_range(crowd - 1));
    else if (pins_live > 0 && roll < 90) p = 8'($urandom_range(pins_live - 1));
    else p = 8'($urandom_range(255));
    h  = ($urandom_range(99) < 85) ? pin_handle[p] : 16'($urandom);
    v  = 8'($urandom_range(255));
    e  = 8'($urandom_range(255));
    op = OpLookup;
    roll = $urandom_range(99);
    if (roll < 38) begin
      op   = OpBind;
      roll = $urandom_range(99);
      if (roll < 75) v = '0;
      else if (roll < 90) v = 8'($urandom_range(VectorEnd - 1, VecBase));
    end else if (roll < 62) begin
      op = OpUnbind;
    end else if (roll < 82) begin
      op = OpLookup;
    end else if (roll < 85) begin
      op = OpReserve;
    end else if (roll < 95) begin
      op   = OpAddFree;
      roll = $urandom_range(99);
      if (roll < 80) begin
        // short run somewhere in the managed range
        first = $urandom_range(VectorEnd - 1, VecBase);
        stop  = first + 1 + $urandom_range(3);
        if (stop > VectorEnd) stop = VectorEnd;
        v = 8'(first);
        e = 8'(stop);
      end else if (roll < 85) begin
        // near-full run: slow walk, keep it rare
        v = 8'(VecBase + $urandom_range(7));
        e = 8'(VectorEnd - $urandom_range(7));
      end
    end else if (roll < 97) begin
      op = OpAddFree + 3'($urandom_range(3, 1));
    end else begin
      op = 3'($urandom);
    end
    offer_txn(op, p, v, e, h);
  endtask

  initial begin : stimulus
    logic [8:0] pin_count_value;
    int         items;
    foreach (pin_handle[i]) pin_handle[i] = 16'($urandom);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Before any pin_count write every pin is out of range.
    offer_txn(OpLookup, 8'd0, 8'd0, 8'd0, 16'h0000);
    offer_txn(OpBind, 8'd0, 8'd0, 8'd0, 16'h0000);
    offer_txn(OpAddFree + 3'd1, 8'd0, 8'd0, 8'd0, 16'h0000);
    offer_txn(OpAddFree + 3'd3, 8'hff, 8'hff, 8'hff, 16'hffff);
    // Bad ranges: start below the base, empty run, end past the top.
    offer_txn(OpAddFree, 8'd0, VecBase - 8'd1, 8'h22, 16'h0000);
    offer_txn(OpAddFree, 8'd0, 8'h30, 8'h30, 16'h0000);
    offer_txn(OpAddFree, 8'd0, 8'h30, VecEnd8 + 8'd1, 16'h0000);
    // Two-vector run ending exactly at the top of the range.
    offer_txn(OpAddFree, 8'd0, VecEnd8 - 8'd2, VecEnd8, 16'h0000);

    // Above the pin limit: clamps to every pin. Pool is not empty, so no seed.
    write_pin_count(9'h1ff);
    offer_txn(OpBind, 8'd255, 8'd0, 8'd0, 16'hffff);
    offer_txn(OpBind, 8'd0, 8'd0, 8'd0, 16'h0000);
    // Pool now empty: dynamic bind fails, a requested one still works.
    offer_txn(OpBind, 8'd1, 8'd0, 8'd0, 16'h8001);
    offer_txn(OpBind, 8'd1, VecBase, 8'd0, 16'h8001);
    offer_txn(OpBind, 8'd3, VecEnd8, 8'd0, 16'h0000);
    offer_txn(OpBind, 8'd3, VecBase - 8'd1, 8'd0, 16'h0000);
    offer_txn(OpBind, 8'd255, 8'h40, 8'd0, 16'h0000);
    // Reserved pin: second reserve, bind, lookup and unbind all fail.
    offer_txn(OpReserve, 8'd2, 8'd0, 8'd0, 16'h0000);
    offer_txn(OpReserve, 8'd2, 8'd0, 8'd0, 16'h0000);
    offer_txn(OpBind, 8'd2, 8'h50, 8'd0, 16'h0000);
    offer_txn(OpLookup, 8'd2, 8'd0, 8'd0, 16'h0000);
    offer_txn(OpUnbind, 8'd2, 8'd0, 8'd0, 16'h0000);
    offer_txn(OpLookup, 8'd255, 8'd0, 8'd0, 16'h0000);
    // Wrong handle leaves the binding; right handle frees the vector.
    offer_txn(OpUnbind, 8'd255, 8'd0, 8'd0, 16'h1234);
    offer_txn(OpUnbind, 8'd255, 8'd0, 8'd0, 16'hffff);
    // Take it again so the pool is empty for the next write, which seeds it.
    offer_txn(OpBind, 8'd4, 8'd0, 8'd0, 16'h00ff);
    write_pin_count(9'd256);

    // Random phases: sender idles lightly and the receiver heavily, then the
    // reverse, then neither, with one long receiver hold-off in the last stretch.
    for (int ph = 0; ph < PhaseCount; ph++) begin
      send_idle_pct = (ph < 2) ? 13 : (ph < 4) ? 70 : 0;
      recv_idle_pct = (ph < 2) ? 70 : (ph < 4) ? 13 : 0;
      case (ph)
        0: pin_count_value = 9'd256;
        1: pin_count_value = 9'd1;
        2: pin_count_value = 9'($urandom_range(255, 2));
        3: pin_count_value = 9'd0;
        4: pin_count_value = 9'($urandom_range(511, 257));
        default: pin_count_value = 9'd200;
      endcase
      items = (ph == 1 || ph == 3) ? 50 : 225;
      write_pin_count(pin_count_value);
      if (ph == 4) hold_stamp++;
      repeat (items) random_txn();
    end

    // Drain: let every reply come home, then allow for any late activity.
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin : watchdog
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: irq_vector_allocator_binder.f
rtl/ivab_pkg.sv
rtl/ivab_pin_table.sv
rtl/ivab_vec_store.sv
rtl/irq_vector_allocator_binder.sv
tb/ivab_reply_checker.sv
tb/tb_irq_vector_allocator_binder.sv
